// ===== hdl/flow_frame_integrator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the flow frame integrator
// ---------------------------------------------------------------------------
`ifndef FLOW_FRAME_INTEGRATOR_MACROS_SVH
`define FLOW_FRAME_INTEGRATOR_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define FFI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define FFI_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ffi_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffi_pkg
// Types, constants and CRC helpers for the flow frame integrator.
// ---------------------------------------------------------------------------
package ffi_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic signed [16:0] FLOW_BIAS   = 17'sd24576;
	localparam logic [15:0]        FLOW_MARKER = 16'hFFFF;

	localparam logic [3:0] NIB_AIR    = 4'h1;
	localparam logic [3:0] NIB_OXYGEN = 4'h0;
	localparam logic [3:0] NIB_MIX    = 4'h6;
	localparam logic [6:0] MIX_MAX    = 7'd100;

	localparam logic [1:0] GAS_AIR    = 2'd0;
	localparam logic [1:0] GAS_OXYGEN = 2'd1;

	localparam logic [1:0] REG_GAS_MODE    = 2'd0;
	localparam logic [1:0] REG_MIX_PERCENT = 2'd1;
	localparam logic [1:0] REG_LOW_FLOW    = 2'd2;
	localparam logic [1:0] REG_QUIET_TIME  = 2'd3;

	localparam logic [15:0] LOW_FLOW_RESET   = 16'd17;
	localparam logic [23:0] QUIET_TIME_RESET = 24'd300000;

	localparam logic signed [63:0] VOL_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] VOL_MIN = {1'b1, {63{1'b0}}};

	typedef enum logic [1:0] {
		ACT_UNCHECKED = 2'd0,
		ACT_OK        = 2'd1,
		ACT_RESTART   = 2'd2,
		ACT_RECONFIG  = 2'd3
	} ffi_action_t;

	typedef struct packed {
		logic [1:0]  gas_mode;
		logic [6:0]  mix_percent;
		logic [15:0] low_flow_threshold;
		logic [23:0] quiet_reset_time_us;
	} ffi_cfg_t;

	// One frame after CRC check and decode.
	typedef struct packed {
		logic               flow_ok;
		logic               flow_marker;
		logic signed [16:0] code;
		logic               temp_ok;
		logic [15:0]        temp;
		logic               stat_ok;
		logic [15:0]        stat;
		ffi_action_t        action;
		logic [23:0]        elapsed_us;
		logic               clear_volume;
	} ffi_frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// True when the CRC byte in bits 7:0 matches the two data bytes.
	function automatic logic crc8_word_ok(input logic [23:0] w);
		logic [7:0] c;
		c = crc8_byte(CRC_INIT, w[23:16]);
		c = crc8_byte(c, w[15:8]);
		return c == w[7:0];
	endfunction

endpackage

// ===== hdl/ffi_frame_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffi_frame_check
// CRC check of the three words, flow code decode and status check.
// ---------------------------------------------------------------------------
module ffi_frame_check (
	input  logic [23:0]       flow_word,
	input  logic [23:0]       temp_word,
	input  logic [23:0]       status_word,
	input  logic [23:0]       elapsed_us,
	input  logic              clear_volume,
	input  ffi_pkg::ffi_cfg_t cfg,
	output ffi_pkg::ffi_frame_t frame
);
	import ffi_pkg::*;

	logic [15:0] flow_raw;
	logic [15:0] stat_raw;
	logic [6:0]  want_mix;

	assign flow_raw = flow_word[23:8];
	assign stat_raw = status_word[23:8];
	assign want_mix = (cfg.mix_percent > MIX_MAX) ? MIX_MAX : cfg.mix_percent;

	always_comb begin
		frame.flow_ok      = crc8_word_ok(flow_word);
		frame.flow_marker  = (flow_raw == FLOW_MARKER);
		frame.code         = {flow_raw[15], flow_raw} + FLOW_BIAS;
		frame.temp_ok      = crc8_word_ok(temp_word);
		frame.temp         = temp_word[23:8];
		frame.stat_ok      = crc8_word_ok(status_word);
		frame.stat         = stat_raw;
		frame.elapsed_us   = elapsed_us;
		frame.clear_volume = clear_volume;

		// mode nibble first, then the mix field in mix mode
		case (cfg.gas_mode)
			GAS_AIR: begin
				frame.action = (stat_raw[15:12] == NIB_AIR) ? ACT_OK : ACT_RESTART;
			end
			GAS_OXYGEN: begin
				frame.action = (stat_raw[15:12] == NIB_OXYGEN) ? ACT_OK : ACT_RESTART;
			end
			default: begin
				if (stat_raw[15:12] != NIB_MIX)
					frame.action = ACT_RESTART;
				else if (stat_raw[9:0] != {3'b000, want_mix})
					frame.action = ACT_RECONFIG;
				else
					frame.action = ACT_OK;
			end
		endcase
		if (!frame.stat_ok)
			frame.action = ACT_UNCHECKED;
	end

endmodule

// ===== hdl/ffi_volume_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffi_volume_core
// Frame state: trapezoidal volume sum, quiet timer and held readings.
// ---------------------------------------------------------------------------
module ffi_volume_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ffi_pkg::ffi_frame_t frame,
	input  ffi_pkg::ffi_cfg_t   cfg,
	output logic signed [16:0]  flow_code,
	output logic                flow_invalid,
	output logic [15:0]         temperature_code,
	output logic [15:0]         status_value,
	output logic signed [63:0]  volume_sum,
	output logic [2:0]          crc_fail_mask,
	output logic [1:0]          action,
	output logic [31:0]         frame_count
);
	import ffi_pkg::*;

	logic signed [16:0] last_flow_q;
	logic               flow_bad_q;
	logic [15:0]        temp_q;
	logic [15:0]        stat_q;
	logic signed [63:0] volume_q;
	logic [31:0]        quiet_q;
	logic [31:0]        pending_q;
	logic [31:0]        frames_q;
	logic [2:0]         mask_q;
	ffi_action_t        action_q;

	logic [32:0]        dt_sum;
	logic [31:0]        dt;
	logic               flow_used;
	logic signed [17:0] code_sum;
	logic signed [50:0] prod;
	logic signed [63:0] vol_base;
	logic signed [64:0] vol_add;
	logic signed [63:0] vol_sat;
	logic [16:0]        mag;
	logic [32:0]        quiet_sum;
	logic [31:0]        quiet_next;
	logic signed [63:0] vol_next;

	always_comb begin
		dt_sum    = {1'b0, pending_q} + {9'd0, frame.elapsed_us};
		dt        = dt_sum[32] ? '1 : dt_sum[31:0];
		flow_used = frame.flow_ok && !frame.flow_marker;

		code_sum = {last_flow_q[16], last_flow_q} + {frame.code[16], frame.code};
		prod     = code_sum * $signed({1'b0, dt});

		vol_base = frame.clear_volume ? '0 : volume_q;
		vol_add  = {vol_base[63], vol_base} + 65'(prod);
		if (vol_add[64] != vol_add[63])
			vol_sat = vol_add[64] ? VOL_MIN : VOL_MAX;
		else
			vol_sat = vol_add[63:0];

		mag       = frame.code[16] ? 17'(-frame.code) : frame.code;
		quiet_sum = {1'b0, quiet_q} + {1'b0, dt};
		if (mag < {1'b0, cfg.low_flow_threshold})
			quiet_next = quiet_sum[32] ? '1 : quiet_sum[31:0];
		else
			quiet_next = '0;

		// drop the volume once the flow has been quiet longer than a nonzero quiet time
		if (cfg.quiet_reset_time_us != '0 && quiet_next > {8'd0, cfg.quiet_reset_time_us})
			vol_next = '0;
		else
			vol_next = vol_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flow_q <= '0;
			flow_bad_q  <= 1'b0;
			temp_q      <= '0;
			stat_q      <= '0;
			volume_q    <= '0;
			quiet_q     <= '0;
			pending_q   <= '0;
			frames_q    <= '0;
			mask_q      <= '0;
			action_q    <= ACT_UNCHECKED;
		end else if (fire) begin
			if (flow_used) begin
				last_flow_q <= frame.code;
				flow_bad_q  <= 1'b0;
				volume_q    <= vol_next;
				quiet_q     <= quiet_next;
				pending_q   <= '0;
			end else begin
				if (frame.flow_ok)
					flow_bad_q <= 1'b1;
				volume_q  <= vol_base;
				pending_q <= dt;
			end
			if (frame.temp_ok)
				temp_q <= frame.temp;
			if (frame.stat_ok)
				stat_q <= frame.stat;
			mask_q   <= {!frame.stat_ok, !frame.temp_ok, !frame.flow_ok};
			action_q <= frame.action;
			frames_q <= frames_q + 32'd1;
		end
	end

	assign flow_code        = last_flow_q;
	assign flow_invalid     = flow_bad_q;
	assign temperature_code = temp_q;
	assign status_value     = stat_q;
	assign volume_sum       = volume_q;
	assign crc_fail_mask    = mask_q;
	assign action           = action_q;
	assign frame_count      = frames_q;

endmodule

// ===== hdl/flow_frame_integrator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flow_frame_integrator
// CRC-checked flow sensor frame decode with trapezoidal volume integration.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) transfers one sensor frame: the
//   flow, temperature and status words with their CRC bytes, the time since
//   the previous frame and a volume clear request. The output channel
//   (out_valid / out_ready) transfers one result per frame: the held flow,
//   temperature and status readings, the volume sum, the CRC failure mask,
//   the status action code and the frame count.
//   out_valid rises once the frame has passed the input register and the
//   decode register and has landed in the result register.
//   Throughput is one frame per cycle while the receiver does not stall;
//   it is set by the integrator stage, whose dt add, 18x33 multiply and
//   saturating 64-bit add close combinationally on the frame state.
//   Reset clears all frame state and loads the register reset values.
//   When the receiver stalls, the result holds and the earlier stages keep
//   taking frames until each of them is full, then in_ready drops.
//   Write configuration through cfg_we / cfg_index / cfg_data only while
//   no frame is in flight.
// ---------------------------------------------------------------------------
`include "flow_frame_integrator_macros.svh"

module flow_frame_integrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        flow_word,
	input  logic [23:0]        temp_word,
	input  logic [23:0]        status_word,
	input  logic [23:0]        elapsed_us,
	input  logic               clear_volume,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] flow_code,
	output logic               flow_invalid,
	output logic [15:0]        temperature_code,
	output logic [15:0]        status_value,
	output logic signed [63:0] volume_sum,
	output logic [2:0]         crc_fail_mask,
	output logic [1:0]         action,
	output logic [31:0]        frame_count
);
	import ffi_pkg::*;

	ffi_cfg_t   cfg_q;

	// input register
	logic        valid_s1;
	logic [23:0] flow_word_s1;
	logic [23:0] temp_word_s1;
	logic [23:0] status_word_s1;
	logic [23:0] elapsed_us_s1;
	logic        clear_volume_s1;

	// decode register
	logic        valid_s2;
	ffi_frame_t  frame_dec;
	ffi_frame_t  frame_s2;

	logic        out_valid_q;
	logic        en_out;
	logic        en_s2;
	logic        en_s1;
	logic        fire;

	// Each stage advances when it is empty or the stage after it advances.
	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign fire     = valid_s2 && en_out;
	assign out_valid = out_valid_q;

	// Configuration registers: take the write in the same edge, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gas_mode            <= GAS_AIR;
			cfg_q.mix_percent         <= '0;
			cfg_q.low_flow_threshold  <= LOW_FLOW_RESET;
			cfg_q.quiet_reset_time_us <= QUIET_TIME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAS_MODE:    cfg_q.gas_mode            <= cfg_data[1:0];
				REG_MIX_PERCENT: cfg_q.mix_percent         <= cfg_data[6:0];
				REG_LOW_FLOW:    cfg_q.low_flow_threshold  <= cfg_data[15:0];
				REG_QUIET_TIME:  cfg_q.quiet_reset_time_us <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_out)
				out_valid_q <= valid_s2;
		end
	end

	// Capture the frame on each input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			flow_word_s1    <= flow_word;
			temp_word_s1    <= temp_word;
			status_word_s1  <= status_word;
			elapsed_us_s1   <= elapsed_us;
			clear_volume_s1 <= clear_volume;
		end
	end

	ffi_frame_check u_check (
		.flow_word    (flow_word_s1),
		.temp_word    (temp_word_s1),
		.status_word  (status_word_s1),
		.elapsed_us   (elapsed_us_s1),
		.clear_volume (clear_volume_s1),
		.cfg          (cfg_q),
		.frame        (frame_dec)
	);

	// Hold the decoded frame until the integrator takes it.
	always_ff @(posedge clk) begin
		if (valid_s1 && en_s2)
			frame_s2 <= frame_dec;
	end

	// The state registers of the core are the result register: they change
	// only when a frame moves into the output stage.
	ffi_volume_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.frame            (frame_s2),
		.cfg              (cfg_q),
		.flow_code        (flow_code),
		.flow_invalid     (flow_invalid),
		.temperature_code (temperature_code),
		.status_value     (status_value),
		.volume_sum       (volume_sum),
		.crc_fail_mask    (crc_fail_mask),
		.action           (action),
		.frame_count      (frame_count)
	);

	// A stalled result must not be overwritten by the integrator.
	`FFI_ASSERT(a_stall_holds, out_valid && !out_ready |=> $stable(volume_sum) && $stable(frame_count), "result changed while stalled")
	// Every frame entering the output stage counts exactly once.
	`FFI_ASSERT(a_count_step, fire |=> frame_count == $past(frame_count) + 32'd1, "frame count did not advance")
	// An empty input register always accepts.
	`FFI_NEVER(a_ready_empty, !valid_s1 && !in_ready, "input stalled with empty stage")

endmodule
